/* rtl/core/lab_pkg.sv */
package lab_pkg;

    // Input word: what to do and where
    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_COMPUTE = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [7:0]  grey_level;
        logic [7:0]  column;
        logic [7:0]  line;
    } t_in_word;

    typedef struct packed {
        logic        foreground;
        logic        results_ready;
        logic [14:0] largest_deviation;
        logic [7:0]  darkest_level;
    } t_out_word;

    // Threshold rules; the spare code falls back to Niblack
    localparam logic [1:0] MODE_SAUVOLA = 2'd1;
    localparam logic [1:0] MODE_WOLF    = 2'd2;

    // Register indexes
    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_WIN_W     = 3'd1;
    localparam logic [2:0] CFG_WIN_H     = 3'd2;
    localparam logic [2:0] CFG_GAIN_K    = 3'd3;
    localparam logic [2:0] CFG_DEV_RANGE = 3'd4;
    localparam logic [2:0] CFG_IMG_W     = 3'd5;
    localparam logic [2:0] CFG_IMG_H     = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Arithmetic widths, fixed by the 7-bit window registers
    localparam int WIN_W  = 7;
    localparam int AREA_W = 14;
    localparam int SUM_W  = 22;
    localparam int SQ_W   = 30;
    localparam int NUM_W  = 44;
    localparam int MEAN_W = 16;
    localparam int DEV_W  = 15;
    localparam int DIV_W  = 64;
    localparam int DVS_W  = 32;
    localparam int MUL_W  = 33;

endpackage

/* rtl/core/local_adaptive_binarizer_core.sv */
// Channel  Direction  Handshake                Payload
// in       input      i_in_valid / o_in_ready  i_in_data  (lab_pkg::t_in_word)
// out      output     o_out_valid / i_out_ready o_out_data (lab_pkg::t_out_word)
// cfg      input      i_cfg_wr_en              i_cfg_index, i_cfg_data
//
// Compute runs a darkest-level pass over the image, then a window scan at each full
// window centre (window scan, mean and variance division, square root), and last a
// threshold pass over every pixel. The one-bit-per-cycle shared divider and the
// single pixel memory port set the pace of these passes.
// Reset is synchronous, active low; memories are not cleared.
// o_in_ready is high only while idle; a waiting result word does not block it.
module local_adaptive_binarizer_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_WINDOW = 127
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  lab_pkg::t_in_word                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output lab_pkg::t_out_word               o_out_data,
    input  logic                             i_cfg_wr_en,
    input  logic [lab_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lab_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int XSW     = $clog2(MAX_WIDTH + 1);
    localparam int YSW     = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADW     = $clog2(DEPTH);
    localparam int WIN_CAP = (MAX_WINDOW - 1) | 1;

    typedef enum logic [4:0] {
        S_IDLE, S_RDW, S_OUT, S_CINIT, S_DSCAN, S_DEND, S_AREA, S_AREA2, S_AREA3,
        S_WINIT, S_WSCAN, S_WEND, S_MEAN, S_DIV, S_M1, S_M2, S_M3, S_SQI, S_SQ,
        S_STORE, S_TRD, S_TA, S_TB, S_TD, S_TCMP, S_DONE
    } t_state;

    function automatic logic [15:0] f_eff_dim(input logic [8:0] v, input int cap);
        logic [15:0] r;
        if (v == '0) begin
            r = 16'd1;
        end else if (int'(v) > cap) begin
            r = 16'(cap);
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    function automatic logic [lab_pkg::WIN_W-1:0] f_eff_win(input logic [6:0] v,
                                                            input logic [15:0] ext);
        logic [15:0] w;
        logic [15:0] lim;
        w   = {9'd0, v[6:1], 1'b1};
        lim = (ext - 16'd1) | 16'd1;
        if (int'(w) > WIN_CAP) begin
            w = 16'(WIN_CAP);
        end
        if (w > lim) begin
            w = lim;
        end
        return w[lab_pkg::WIN_W-1:0];
    endfunction

    function automatic logic [ADW-1:0] f_adr(input logic [XSW-1:0] x, input logic [YSW-1:0] y);
        return ADW'(32'(y) * MAX_WIDTH + 32'(x));
    endfunction

    // configuration
    logic [1:0]        r_mode;
    logic [6:0]        r_win_w, r_win_h;
    logic signed [15:0] r_gain_k;
    logic [7:0]        r_dev_range;
    logic [8:0]        r_img_w, r_img_h;

    t_state            r_state;
    logic              r_out_valid;
    lab_pkg::t_out_word r_out_data;
    logic              r_ready;
    logic [14:0]       r_max_dev;
    logic [7:0]        r_min;
    logic [XSW-1:0]    r_done_w;
    logic [YSW-1:0]    r_done_h;
    logic              r_fg, r_rd_ok;

    logic [XSW-1:0]    r_w, r_x, r_cx;
    logic [YSW-1:0]    r_h, r_y, r_cy;
    logic [6:0]        r_ww, r_wh, r_wx, r_wy;
    logic [5:0]        r_hx, r_hy;
    logic [7:0]        r_rng, r_dark;
    logic [14:0]       r_big_s;
    logic [lab_pkg::AREA_W-1:0]   r_area;
    logic [2*lab_pkg::AREA_W-1:0] r_area2;
    logic [lab_pkg::SUM_W-1:0]    r_sum;
    logic [lab_pkg::SQ_W-1:0]     r_sq;
    logic [lab_pkg::NUM_W-1:0]    r_num_a;
    logic [lab_pkg::MEAN_W-1:0]   r_mean;
    logic              r_pv_dark, r_pv_win;
    logic signed [2*lab_pkg::MUL_W-1:0] r_prod;

    // shared divider
    logic [lab_pkg::DIV_W-1:0] r_dq;
    logic [lab_pkg::DVS_W:0]   r_rem;
    logic [lab_pkg::DVS_W-1:0] r_dvs;
    logic [6:0]        r_cnt;
    t_state            r_after;
    logic              r_neg;

    // square root
    logic [31:0]       r_rad;
    logic [17:0]       r_sq_rem;
    logic [15:0]       r_root;
    logic [3:0]        r_sqc;

    // memories
    logic [7:0]                  pixel_mem [DEPTH];
    logic                        bin_mem   [DEPTH];
    logic [lab_pkg::MEAN_W-1:0]  mean_mem  [DEPTH];
    logic [lab_pkg::DEV_W-1:0]   dev_mem   [DEPTH];
    logic [7:0]                  r_pix_q;
    logic                        r_bin_q;
    logic [lab_pkg::MEAN_W-1:0]  r_mean_q;
    logic [lab_pkg::DEV_W-1:0]   r_dev_q;

    logic        in_acc;
    logic [15:0] eff_w16, eff_h16;
    logic [6:0]  eff_ww, eff_wh;
    logic        load_ok, read_ok, pix_we;
    logic [ADW-1:0] in_adr, pix_radr, ctr_adr, cur_adr, cen_adr;
    logic [XSW-1:0] win_x, cxc, clo_x, chi_x;
    logic [YSW-1:0] win_y, cyc, clo_y, chi_y;
    logic signed [lab_pkg::MUL_W-1:0] mul_a, mul_b;
    logic signed [2*lab_pkg::MUL_W-1:0] mul_p;
    logic [lab_pkg::NUM_W-1:0] var_num;
    logic [lab_pkg::DVS_W-1:0] thr_den;
    logic signed [63:0] thr_a, thr_q, thr_t;
    logic        thr_fg;
    logic [lab_pkg::DVS_W:0] rem_sh;
    logic        div_ge;
    logic [19:0] sq_sh, sq_trial;
    logic        sq_ge;
    logic [14:0] dev_s;
    logic        last_x, last_y, last_wx, last_wy, last_cx, last_cy;

    assign in_acc  = i_in_valid && o_in_ready;
    assign eff_w16 = f_eff_dim(r_img_w, MAX_WIDTH);
    assign eff_h16 = f_eff_dim(r_img_h, MAX_HEIGHT);
    assign eff_ww  = f_eff_win(r_win_w, eff_w16);
    assign eff_wh  = f_eff_win(r_win_h, eff_h16);
    assign load_ok = (16'(i_in_data.column) < eff_w16) && (16'(i_in_data.line) < eff_h16);
    assign read_ok = r_ready && (16'(i_in_data.column) < 16'(r_done_w))
                     && (16'(i_in_data.line) < 16'(r_done_h));
    assign in_adr  = f_adr(XSW'(i_in_data.column), YSW'(i_in_data.line));
    assign pix_we  = in_acc && (i_in_data.action == lab_pkg::ACT_LOAD) && load_ok;

    assign win_x   = XSW'(r_cx - XSW'(r_hx) + XSW'(r_wx));
    assign win_y   = YSW'(r_cy - YSW'(r_hy) + YSW'(r_wy));
    assign cur_adr = f_adr(r_x, r_y);
    assign ctr_adr = f_adr(r_cx, r_cy);

    // nearest valid window centre for the threshold pass
    assign clo_x   = XSW'(r_hx);
    assign chi_x   = XSW'(r_w - XSW'(1) - clo_x);
    assign clo_y   = YSW'(r_hy);
    assign chi_y   = YSW'(r_h - YSW'(1) - clo_y);
    assign cxc     = (r_x < clo_x) ? clo_x : ((r_x > chi_x) ? chi_x : r_x);
    assign cyc     = (r_y < clo_y) ? clo_y : ((r_y > chi_y) ? chi_y : r_y);
    assign cen_adr = f_adr(cxc, cyc);

    assign pix_radr = (r_state == S_WSCAN) ? f_adr(win_x, win_y) : cur_adr;

    assign last_x  = (r_x == XSW'(r_w - XSW'(1)));
    assign last_y  = (r_y == YSW'(r_h - YSW'(1)));
    assign last_wx = (r_wx == r_ww - 7'd1);
    assign last_wy = (r_wy == r_wh - 7'd1);
    assign last_cx = (r_cx == chi_x);
    assign last_cy = (r_cy == chi_y);

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_AREA: begin
                mul_a = lab_pkg::MUL_W'(r_ww);
                mul_b = lab_pkg::MUL_W'(r_wh);
            end
            S_AREA2: begin
                mul_a = lab_pkg::MUL_W'(r_prod[lab_pkg::AREA_W-1:0]);
                mul_b = lab_pkg::MUL_W'(r_prod[lab_pkg::AREA_W-1:0]);
            end
            S_M1: begin
                mul_a = lab_pkg::MUL_W'(r_area);
                mul_b = lab_pkg::MUL_W'(r_sq);
            end
            S_M2: begin
                mul_a = lab_pkg::MUL_W'(r_sum);
                mul_b = lab_pkg::MUL_W'(r_sum);
            end
            S_TA: begin
                if (r_mode == lab_pkg::MODE_SAUVOLA) begin
                    mul_a = lab_pkg::MUL_W'(r_mean_q);
                    mul_b = lab_pkg::MUL_W'(r_gain_k);
                end else if (r_mode == lab_pkg::MODE_WOLF) begin
                    mul_a = lab_pkg::MUL_W'(r_gain_k);
                    mul_b = $signed(lab_pkg::MUL_W'(r_dev_q)) - $signed(lab_pkg::MUL_W'(r_big_s));
                end else begin
                    mul_a = lab_pkg::MUL_W'(r_gain_k);
                    mul_b = lab_pkg::MUL_W'(r_dev_q);
                end
            end
            S_TB: begin
                mul_a = r_prod[lab_pkg::MUL_W-1:0];
                if (r_mode == lab_pkg::MODE_SAUVOLA) begin
                    mul_b = $signed(lab_pkg::MUL_W'(r_dev_q))
                            - $signed(lab_pkg::MUL_W'({r_rng, 8'd0}));
                end else if (r_mode == lab_pkg::MODE_WOLF) begin
                    // flat image: product forced to zero, threshold is the mean
                    mul_b = (r_big_s == '0) ? '0 :
                            $signed(lab_pkg::MUL_W'(r_mean_q))
                            - $signed(lab_pkg::MUL_W'({r_dark, 8'd0}));
                end else begin
                    mul_b = lab_pkg::MUL_W'(1);
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign var_num = r_num_a - r_prod[lab_pkg::NUM_W-1:0];

    always_comb begin
        if (r_mode == lab_pkg::MODE_SAUVOLA) begin
            thr_den = lab_pkg::DVS_W'({r_rng, 20'd0});
        end else if (r_mode == lab_pkg::MODE_WOLF) begin
            thr_den = (r_big_s == '0) ? lab_pkg::DVS_W'(1) : lab_pkg::DVS_W'({r_big_s, 12'd0});
        end else begin
            thr_den = lab_pkg::DVS_W'(4096);
        end
    end

    // rounding half up: floor((n + d/2) / d), sign handled around the unsigned divider
    assign thr_a  = 64'(r_prod) + $signed(64'(thr_den >> 1));
    assign thr_q  = r_neg ? (-$signed(r_dq) - ((r_rem != '0) ? 64'sd1 : 64'sd0))
                          : $signed(r_dq);
    assign thr_t  = thr_q + $signed(64'(r_mean_q));
    assign thr_fg = $signed(64'({r_pix_q, 8'd0})) >= thr_t;

    assign rem_sh = {r_rem[lab_pkg::DVS_W-1:0], r_dq[lab_pkg::DIV_W-1]};
    assign div_ge = rem_sh >= {1'b0, r_dvs};

    assign sq_sh    = {r_sq_rem, r_rad[31:30]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign dev_s    = (r_root > 16'h7FFF) ? 15'h7FFF : r_root[14:0];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= '0;
            r_win_w     <= 7'd15;
            r_win_h     <= 7'd15;
            r_gain_k    <= 16'sd410;
            r_dev_range <= 8'd128;
            r_img_w     <= 9'd256;
            r_img_h     <= 9'd256;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                lab_pkg::CFG_MODE:      r_mode      <= i_cfg_data[1:0];
                lab_pkg::CFG_WIN_W:     r_win_w     <= i_cfg_data[6:0];
                lab_pkg::CFG_WIN_H:     r_win_h     <= i_cfg_data[6:0];
                lab_pkg::CFG_GAIN_K:    r_gain_k    <= $signed(i_cfg_data);
                lab_pkg::CFG_DEV_RANGE: r_dev_range <= i_cfg_data[7:0];
                lab_pkg::CFG_IMG_W:     r_img_w     <= i_cfg_data[8:0];
                lab_pkg::CFG_IMG_H:     r_img_h     <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            pixel_mem[in_adr] <= i_in_data.grey_level;
        end
        r_pix_q <= pixel_mem[pix_radr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_TCMP) begin
            bin_mem[cur_adr] <= thr_fg;
        end
        r_bin_q <= bin_mem[in_adr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_STORE) begin
            mean_mem[ctr_adr] <= r_mean;
            dev_mem[ctr_adr]  <= dev_s;
        end
        r_mean_q <= mean_mem[cen_adr];
        r_dev_q  <= dev_mem[cen_adr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ready     <= 1'b0;
            r_max_dev   <= '0;
            r_min       <= 8'hFF;
            r_done_w    <= '0;
            r_done_h    <= '0;
            r_pv_dark   <= 1'b0;
            r_pv_win    <= 1'b0;
        end else begin
            r_prod    <= mul_p;
            r_pv_dark <= (r_state == S_DSCAN);
            r_pv_win  <= (r_state == S_WSCAN);
            if (r_pv_dark && (r_pix_q < r_dark)) begin
                r_dark <= r_pix_q;
            end
            if (r_pv_win) begin
                r_sum <= r_sum + lab_pkg::SUM_W'(r_pix_q);
                r_sq  <= r_sq + lab_pkg::SQ_W'({8'd0, r_pix_q} * {8'd0, r_pix_q});
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_in_data.action)
                            lab_pkg::ACT_LOAD: begin
                                if (load_ok) begin
                                    r_ready <= 1'b0;
                                end
                                r_fg    <= 1'b0;
                                r_state <= S_OUT;
                            end
                            lab_pkg::ACT_COMPUTE: r_state <= S_CINIT;
                            lab_pkg::ACT_READ: begin
                                r_rd_ok <= read_ok;
                                r_state <= S_RDW;
                            end
                            lab_pkg::ACT_NONE: begin
                                r_fg    <= 1'b0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_RDW: begin
                    r_fg    <= r_bin_q & r_rd_ok;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_data.foreground        <= r_fg;
                        r_out_data.results_ready     <= r_ready;
                        r_out_data.largest_deviation <= r_max_dev;
                        r_out_data.darkest_level     <= r_min;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_CINIT: begin
                    r_w     <= eff_w16[XSW-1:0];
                    r_h     <= eff_h16[YSW-1:0];
                    r_ww    <= eff_ww;
                    r_wh    <= eff_wh;
                    r_hx    <= eff_ww[6:1];
                    r_hy    <= eff_wh[6:1];
                    r_rng   <= (r_dev_range == '0) ? 8'd1 : r_dev_range;
                    r_x     <= '0;
                    r_y     <= '0;
                    r_dark  <= 8'hFF;
                    r_state <= S_DSCAN;
                end
                S_DSCAN: begin
                    if (last_x) begin
                        r_x <= '0;
                        if (last_y) begin
                            r_state <= S_DEND;
                        end else begin
                            r_y <= r_y + YSW'(1);
                        end
                    end else begin
                        r_x <= r_x + XSW'(1);
                    end
                end
                S_DEND:  r_state <= S_AREA;
                S_AREA:  r_state <= S_AREA2;
                S_AREA2: begin
                    r_area  <= r_prod[lab_pkg::AREA_W-1:0];
                    r_state <= S_AREA3;
                end
                S_AREA3: begin
                    r_area2 <= r_prod[2*lab_pkg::AREA_W-1:0];
                    r_big_s <= '0;
                    r_cx    <= XSW'(r_hx);
                    r_cy    <= YSW'(r_hy);
                    r_state <= S_WINIT;
                end
                S_WINIT: begin
                    r_sum   <= '0;
                    r_sq    <= '0;
                    r_wx    <= '0;
                    r_wy    <= '0;
                    r_state <= S_WSCAN;
                end
                S_WSCAN: begin
                    if (last_wx) begin
                        r_wx <= '0;
                        if (last_wy) begin
                            r_state <= S_WEND;
                        end else begin
                            r_wy <= r_wy + 7'd1;
                        end
                    end else begin
                        r_wx <= r_wx + 7'd1;
                    end
                end
                S_WEND: r_state <= S_MEAN;
                S_MEAN: begin
                    r_dq    <= {32'({r_sum, 8'd0} + 30'(r_area >> 1)), 32'd0};
                    r_dvs   <= lab_pkg::DVS_W'(r_area);
                    r_rem   <= '0;
                    r_cnt   <= 7'd32;
                    r_after <= S_M1;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= div_ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
                    r_dq  <= {r_dq[lab_pkg::DIV_W-2:0], div_ge};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_state <= r_after;
                    end
                end
                S_M1: begin
                    r_mean  <= r_dq[lab_pkg::MEAN_W-1:0];
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_num_a <= r_prod[lab_pkg::NUM_W-1:0];
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_dq    <= lab_pkg::DIV_W'({var_num, 16'd0});
                    r_dvs   <= lab_pkg::DVS_W'(r_area2);
                    r_rem   <= '0;
                    r_cnt   <= 7'd64;
                    r_after <= S_SQI;
                    r_state <= S_DIV;
                end
                S_SQI: begin
                    r_rad    <= r_dq[31:0];
                    r_sq_rem <= '0;
                    r_root   <= '0;
                    r_sqc    <= 4'd15;
                    r_state  <= S_SQ;
                end
                S_SQ: begin
                    r_sq_rem <= sq_ge ? 18'(sq_sh - sq_trial) : 18'(sq_sh);
                    r_root   <= {r_root[14:0], sq_ge};
                    r_rad    <= {r_rad[29:0], 2'b00};
                    r_sqc    <= r_sqc - 4'd1;
                    if (r_sqc == '0) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    if (dev_s > r_big_s) begin
                        r_big_s <= dev_s;
                    end
                    if (last_cx) begin
                        r_cx <= XSW'(r_hx);
                        if (last_cy) begin
                            r_x     <= '0;
                            r_y     <= '0;
                            r_state <= S_TRD;
                        end else begin
                            r_cy    <= r_cy + YSW'(1);
                            r_state <= S_WINIT;
                        end
                    end else begin
                        r_cx    <= r_cx + XSW'(1);
                        r_state <= S_WINIT;
                    end
                end
                S_TRD: r_state <= S_TA;
                S_TA:  r_state <= S_TB;
                S_TB:  r_state <= S_TD;
                S_TD: begin
                    r_neg   <= thr_a < 0;
                    r_dq    <= (thr_a < 0) ? 64'(-thr_a) : 64'(thr_a);
                    r_dvs   <= thr_den;
                    r_rem   <= '0;
                    r_cnt   <= 7'd64;
                    r_after <= S_TCMP;
                    r_state <= S_DIV;
                end
                S_TCMP: begin
                    if (last_x) begin
                        r_x <= '0;
                        if (last_y) begin
                            r_state <= S_DONE;
                        end else begin
                            r_y     <= r_y + YSW'(1);
                            r_state <= S_TRD;
                        end
                    end else begin
                        r_x     <= r_x + XSW'(1);
                        r_state <= S_TRD;
                    end
                end
                S_DONE: begin
                    r_ready   <= 1'b1;
                    r_max_dev <= r_big_s;
                    r_min     <= r_dark;
                    r_done_w  <= r_w;
                    r_done_h  <= r_h;
                    r_fg      <= 1'b0;
                    r_state   <= S_OUT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/core/lab_checker.sv */
module lab_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_ready,
    input  lab_pkg::t_in_word                i_in_data,
    input  logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  lab_pkg::t_out_word               o_out_data,
    input  logic                             i_cfg_wr_en,
    input  logic [lab_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lab_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // a result word waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before accept");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result word changed while stalled");

    // a set pixel only exists once thresholds are in place
    a_fg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.foreground |-> o_out_data.results_ready)
        else $error("foreground reported without results");

    // compute keeps the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.action == lab_pkg::ACT_COMPUTE)
        |=> !o_in_ready)
        else $error("input taken during compute");

endmodule

bind local_adaptive_binarizer_core lab_checker u_lab_checker (.*);
